@@ rtl/tfd_pkg.sv @@
// shared types and constants for the thiran fractional delay unit
`default_nettype none
package tfd_pkg;

  localparam int unsigned SAMPLE_W        = 24;
  localparam int unsigned DW_W            = 6;
  localparam int unsigned FRAC_W          = 16;
  localparam int unsigned COEFF_W         = 17;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned STORE_DEPTH_DEF = 64;

  localparam logic [COEFF_W-1:0] COEFF_ONE       = 17'h10000;
  // fraction * 10 < 65536 holds up to this value
  localparam logic [FRAC_W-1:0]  BYPASS_FRAC_MAX = 16'd6553;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_WHOLE    = 2'd0,
    CFG_DELAY_FRACTION = 2'd1,
    CFG_ALLPASS_COEFF  = 2'd2
  } cfg_idx_t;

  // where each tap comes from
  typedef struct packed {
    logic fwd_prev;  // tap is the sample written in the same beat
    logic fwd_next;
    logic vld_prev;  // entry has been written since reset
    logic vld_next;
  } tap_flags_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic                       bypass;
    tap_flags_t                 flags;
  } stage_t;

endpackage
`default_nettype wire

@@ rtl/tfd_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none
module tfd_ram #(
  parameter int unsigned WIDTH  = 24,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/tfd_addr.sv @@
// write pointer, fill tracking and tap address generation
`default_nettype none
module tfd_addr #(
  parameter int unsigned STORE_DEPTH = 64,
  parameter int unsigned ADDR_W      = $clog2(STORE_DEPTH)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic [ADDR_W-1:0]  back,
  output logic      [ADDR_W-1:0]  waddr,
  output logic      [ADDR_W-1:0]  rd_prev,
  output logic      [ADDR_W-1:0]  rd_next,
  output tfd_pkg::tap_flags_t     flags
);

  localparam logic [ADDR_W:0]   DEPTH_V = (ADDR_W+1)'(STORE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(STORE_DEPTH - 1);

  logic [ADDR_W-1:0] wptr_r, wptr_nxt;
  logic              full_r, full_nxt;
  logic [ADDR_W:0]   diff;
  logic [ADDR_W-1:0] rp, rn;

  always_comb begin
    diff = {1'b0, wptr_r} + DEPTH_V - {1'b0, back};
    if (diff >= DEPTH_V) begin
      diff = diff - DEPTH_V;
    end
    rp = diff[ADDR_W-1:0];
    rn = (rp == LAST_A) ? '0 : rp + 1'b1;
  end

  always_comb begin
    wptr_nxt = wptr_r;
    full_nxt = full_r;
    if (accept) begin
      wptr_nxt = (wptr_r == LAST_A) ? '0 : wptr_r + 1'b1;
      if (wptr_r == LAST_A) begin
        full_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      full_r <= 1'b0;
    end else begin
      wptr_r <= wptr_nxt;
      full_r <= full_nxt;
    end
  end

  // entries are written in address order after reset, so anything below
  // the write pointer (or everything once wrapped) holds real data
  assign flags.fwd_prev = (rp == wptr_r);
  assign flags.fwd_next = (rn == wptr_r);
  assign flags.vld_prev = full_r || (rp < wptr_r);
  assign flags.vld_next = full_r || (rn < wptr_r);

  assign waddr   = wptr_r;
  assign rd_prev = rp;
  assign rd_next = rn;

endmodule
`default_nettype wire

@@ rtl/tfd_allpass.sv @@
// first-order allpass datapath with output feedback register
`default_nettype none
module tfd_allpass (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  adv,
  input  wire tfd_pkg::stage_t                       stg,
  input  wire logic signed [tfd_pkg::SAMPLE_W-1:0]   prev_q,
  input  wire logic signed [tfd_pkg::SAMPLE_W-1:0]   next_q,
  input  wire logic        [tfd_pkg::COEFF_W-1:0]    coeff,
  output logic signed      [tfd_pkg::SAMPLE_W-1:0]   y
);

  logic signed [tfd_pkg::SAMPLE_W-1:0] last_r, last_nxt;
  logic signed [tfd_pkg::SAMPLE_W-1:0] x_prev, x_next, y_ap;
  logic signed [24:0] diff;
  logic signed [42:0] prod, prod_rnd;
  logic signed [26:0] rnd;
  logic signed [27:0] sum;

  always_comb begin
    x_prev = stg.flags.fwd_prev ? stg.x :
             (stg.flags.vld_prev ? prev_q : '0);
    x_next = stg.flags.fwd_next ? stg.x :
             (stg.flags.vld_next ? next_q : '0);
    diff     = {x_next[23], x_next} - {last_r[23], last_r};
    prod     = $signed({1'b0, coeff}) * diff;
    // round half up, then drop 16 fraction bits
    prod_rnd = prod + 43'sd32768;
    rnd      = prod_rnd[42:16];
    sum      = {{4{x_prev[23]}}, x_prev} + {rnd[26], rnd};
    if (sum > 28'sd8388607) begin
      y_ap = tfd_pkg::SAMPLE_MAX;
    end else if (sum < -28'sd8388608) begin
      y_ap = tfd_pkg::SAMPLE_MIN;
    end else begin
      y_ap = sum[23:0];
    end
    y        = stg.bypass ? stg.x : y_ap;
    last_nxt = (adv && !stg.bypass) ? y_ap : last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else begin
      last_r <= last_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/thiran_fractional_delay_unit.sv @@
// top level of the thiran allpass fractional delay unit
// usage:
//   in_* is a stream of signed Q1.23 samples, one sample per beat. out_*
//   returns exactly one delayed, saturated sample per input beat, in order.
//   cfg_* writes the delay whole part (index 0), the Q0.16 fraction
//   (index 1) and the Q1.16 allpass coefficient (index 2); cfg_ready is
//   always high and writes are meant to happen while the stream is idle.
// pipeline and throughput:
//   an accepted beat is registered with its tap reads in the compute stage,
//   and its result in the output register behind out_tvalid. one beat per
//   cycle sustained while out_tready is high: the tap reads go out of the
//   delay memory in the accept cycle, and the subtract-multiply-round-add
//   loop through the last-output register closes in the compute stage.
// reset:
//   the write pointer and a wrap flag restart, so the delay memory reads
//   as zero until each entry is first written; no clearing sweep is run
//   and in_tready is high right after reset.
// stall:
//   when out_tready is low the output register holds, one more sample sits
//   in the compute stage, and in_tready drops once both are occupied.
`default_nettype none
module thiran_fractional_delay_unit #(
  parameter int unsigned STORE_DEPTH = tfd_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // [23:0] sample_in
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [tfd_pkg::SAMPLE_W-1:0]     in_tdata,
  // [23:0] sample_out
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [tfd_pkg::SAMPLE_W-1:0]     out_tdata,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tfd_pkg::COEFF_W-1:0]      cfg_data
);

  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);

  // tap distance (whole + 1) folded into the store depth, narrow table
  function automatic logic [ADDR_W-1:0] back_of(input logic [tfd_pkg::DW_W:0] v);
    logic [ADDR_W-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << (tfd_pkg::DW_W + 1)); i++) begin
      if (v == (tfd_pkg::DW_W+1)'(i)) begin
        r = ADDR_W'(i % STORE_DEPTH);
      end
    end
    return r;
  endfunction

  // configuration registers
  logic [tfd_pkg::DW_W-1:0]    dw_r, dw_nxt;
  logic [tfd_pkg::FRAC_W-1:0]  frac_r, frac_nxt;
  logic [tfd_pkg::COEFF_W-1:0] coeff_r, coeff_nxt;
  logic [ADDR_W-1:0]           back_r, back_nxt;

  // pipeline control
  logic            in_acc;
  logic            s1_valid_r, s1_valid_nxt;
  tfd_pkg::stage_t s1_r, s1_nxt;
  logic            s1_adv;
  logic            out_valid_r, out_valid_nxt;
  logic [tfd_pkg::SAMPLE_W-1:0] out_data_r, out_data_nxt;

  logic [ADDR_W-1:0]    waddr, rd_prev, rd_next;
  tfd_pkg::tap_flags_t  flags;
  logic signed [tfd_pkg::SAMPLE_W-1:0] prev_q, next_q, y;
  logic                 bypass;

  assign cfg_ready = 1'b1;

  always_comb begin
    dw_nxt    = dw_r;
    frac_nxt  = frac_r;
    coeff_nxt = coeff_r;
    back_nxt  = back_r;
    if (cfg_valid) begin
      case (cfg_index)
        tfd_pkg::CFG_DELAY_WHOLE: begin
          dw_nxt   = cfg_data[tfd_pkg::DW_W-1:0];
          back_nxt = back_of({1'b0, cfg_data[tfd_pkg::DW_W-1:0]} + 1'b1);
        end
        tfd_pkg::CFG_DELAY_FRACTION: begin
          frac_nxt = cfg_data[tfd_pkg::FRAC_W-1:0];
        end
        tfd_pkg::CFG_ALLPASS_COEFF: begin
          // anything above unity is held at unity
          coeff_nxt = cfg_data[tfd_pkg::COEFF_W-1] ? tfd_pkg::COEFF_ONE : cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dw_r    <= '0;
      frac_r  <= '0;
      coeff_r <= tfd_pkg::COEFF_ONE;
      back_r  <= back_of((tfd_pkg::DW_W+1)'(1));
    end else begin
      dw_r    <= dw_nxt;
      frac_r  <= frac_nxt;
      coeff_r <= coeff_nxt;
      back_r  <= back_nxt;
    end
  end

  // near-zero delay passes the sample straight through
  assign bypass = (dw_r == '0) && (frac_r <= tfd_pkg::BYPASS_FRAC_MAX);

  // handshake: compute stage moves when the output register frees up
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  tfd_addr #(
    .STORE_DEPTH (STORE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_addr (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_acc),
    .back    (back_r),
    .waddr   (waddr),
    .rd_prev (rd_prev),
    .rd_next (rd_next),
    .flags   (flags)
  );

  // two copies of the store, one per tap, written alike
  tfd_ram #(
    .WIDTH  (tfd_pkg::SAMPLE_W),
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram_prev (
    .clk   (clk),
    .we    (in_acc),
    .waddr (waddr),
    .wdata (in_tdata),
    .re    (in_acc),
    .raddr (rd_prev),
    .rdata (prev_q)
  );

  tfd_ram #(
    .WIDTH  (tfd_pkg::SAMPLE_W),
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram_next (
    .clk   (clk),
    .we    (in_acc),
    .waddr (waddr),
    .wdata (in_tdata),
    .re    (in_acc),
    .raddr (rd_next),
    .rdata (next_q)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_nxt       = s1_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
      s1_nxt.x      = in_tdata;
      s1_nxt.bypass = bypass;
      s1_nxt.flags  = flags;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  tfd_allpass u_allpass (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (s1_adv),
    .stg    (s1_r),
    .prev_q (prev_q),
    .next_q (next_q),
    .coeff  (coeff_r),
    .y      (y)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = y;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

@@ rtl/tfd_checker.sv @@
// port-level checker for the fractional delay unit, bound to the top level
`default_nettype none
module tfd_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_tvalid,
  input wire logic                         in_tready,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [tfd_pkg::SAMPLE_W-1:0] out_tdata,
  input wire logic                         cfg_valid,
  input wire logic                         cfg_ready
);

  logic [2:0] pend_r, pend_nxt;
  logic       in_beat, out_beat;

  assign in_beat  = in_tvalid && in_tready;
  assign out_beat = out_tvalid && out_tready;

  always_comb begin
    pend_nxt = pend_r + {2'b0, in_beat} - {2'b0, out_beat};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // a stalled result beat holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output beat changed");

  // input backpressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output stall");

  // never more than two samples in flight
  a_pend_max: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd2)
    else $error("too many samples in flight");

  // every output beat belongs to an accepted input beat
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 3'd0)
    else $error("output beat without input beat");

  // configuration writes never wait
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind thiran_fractional_delay_unit tfd_checker u_tfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);
`default_nettype wire
